[hw/rtl/ktpc_pkg.sv]
// Shared types, constants and helper functions of the keypad tone controller.
package ktpc_pkg;

	localparam int DIGIT_COUNT = 5;
	localparam int DIGIT_W     = 4;
	localparam int DEC_BASE    = 10;
	localparam int VAL_W       = $clog2(DEC_BASE ** DIGIT_COUNT);

	localparam int KEY_W   = 5;
	localparam int TICK_W  = 20;
	localparam int FREQ_W  = 17;
	localparam int STEP_W  = 6;
	localparam int DUTY_W  = 7;
	localparam int PER_W   = 16;
	localparam int CMP_W   = (VAL_W > FREQ_W) ? VAL_W : FREQ_W;

	localparam int DVD_W      = TICK_W;
	localparam int DVS_W      = FREQ_W;
	localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
	localparam int PCT_SCALE  = 100;

	// divide by the percent scale as a multiply by its rounded-up reciprocal;
	// exact for every duty times period product
	localparam int PROD_W      = DUTY_W + PER_W;
	localparam int PCT_SHIFT   = 30;
	localparam int PCT_RECIP_W = 24;
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
		PCT_RECIP_W'(((64'd1 << PCT_SHIFT) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE));
	localparam int SCALED_W    = PROD_W + PCT_RECIP_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = TICK_W;

	localparam logic [TICK_W-1:0] TICK_RATE_RST = TICK_W'(48000);
	localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = FREQ_W'(20);
	localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = FREQ_W'(20000);
	localparam logic [STEP_W-1:0] DUTY_STEP_RST = STEP_W'(5);
	localparam logic [DUTY_W-1:0] DUTY_LIM_RST  = DUTY_W'(95);
	localparam logic [DUTY_W-1:0] DUTY_RST      = DUTY_W'(50);

	// key codes, 4*row+column+1
	localparam logic [KEY_W-1:0] KEY_NONE   = KEY_W'(0);
	localparam logic [KEY_W-1:0] KEY_1      = KEY_W'(1);
	localparam logic [KEY_W-1:0] KEY_3      = KEY_W'(3);
	localparam logic [KEY_W-1:0] KEY_DUTY_A = KEY_W'(4);
	localparam logic [KEY_W-1:0] KEY_4      = KEY_W'(5);
	localparam logic [KEY_W-1:0] KEY_6      = KEY_W'(7);
	localparam logic [KEY_W-1:0] KEY_DUTY_B = KEY_W'(8);
	localparam logic [KEY_W-1:0] KEY_7      = KEY_W'(9);
	localparam logic [KEY_W-1:0] KEY_9      = KEY_W'(11);
	localparam logic [KEY_W-1:0] KEY_ERR_A  = KEY_W'(12);
	localparam logic [KEY_W-1:0] KEY_ENTER  = KEY_W'(13);
	localparam logic [KEY_W-1:0] KEY_0      = KEY_W'(14);
	localparam logic [KEY_W-1:0] KEY_DONE   = KEY_W'(15);
	localparam logic [KEY_W-1:0] KEY_ERR_B  = KEY_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_RATE = 3'd0,
		REG_MIN_FREQ  = 3'd1,
		REG_MAX_FREQ  = 3'd2,
		REG_DUTY_STEP = 3'd3,
		REG_DUTY_LIM  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		SPK_A    = 2'd0,
		SPK_B    = 2'd1,
		SPK_BOTH = 2'd2,
		SPK_OFF  = 2'd3
	} spk_mode_t;

	typedef enum logic [1:0] {
		DIV_PERIOD  = 2'd0,
		DIV_PULSE_A = 2'd1,
		DIV_PULSE_B = 2'd2
	} div_sel_t;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [DIGIT_COUNT-1:0] digits_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic             button_level;
	} item_t;

	typedef struct packed {
		logic [PER_W-1:0]  period_ticks;
		logic [PER_W-1:0]  pulse_a;
		logic [PER_W-1:0]  pulse_b;
		logic [FREQ_W-1:0] tone_frequency;
		logic              entering;
		logic              error_flash;
		logic              speaker_a_on;
		logic              speaker_b_on;
	} result_t;

	typedef struct packed {
		logic     load_item;
		logic     div_start;
		div_sel_t div_sel;
		logic     pulse_load;
		logic     pulse_write;
		logic     load_result;
	} cmd_t;

	typedef struct packed {
		logic freq_zero;
		logic period_zero;
		logic div_done;
	} stat_t;

	// digit keys: 1-3, 5-7, 9-11 give 1-9, key 14 gives 0
	function automatic logic [DIGIT_W:0] key_digit(input logic [KEY_W-1:0] key);
		logic [DIGIT_W:0] r;
		r = '0;
		case (key) inside
			[KEY_1:KEY_3]: r = {1'b1, DIGIT_W'(key)};
			[KEY_4:KEY_6]: r = {1'b1, DIGIT_W'(key - KEY_W'(1))};
			[KEY_7:KEY_9]: r = {1'b1, DIGIT_W'(key - KEY_W'(2))};
			KEY_0:         r = {1'b1, DIGIT_W'(0)};
			default:       r = '0;
		endcase
		return r;
	endfunction

	// oldest digit first, so index 0 is the most significant
	function automatic logic [CMP_W-1:0] digits_value(input digits_t d);
		logic [CMP_W-1:0] v;
		v = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			v = CMP_W'(v * CMP_W'(DEC_BASE)) + CMP_W'(d[i]);
		end
		return v;
	endfunction

endpackage

[hw/rtl/keypad_tone_pwm_controller_core.sv]
// Top level of the keypad tone and PWM controller core.
//
//  channel  | signals                            | direction | transfer when
//  ---------+------------------------------------+-----------+-----------------------
//  item     | item_valid, item_stall, item       | in        | valid high, stall low
//  result   | result_valid, result_stall, result | out       | valid high, stall low
//  cfg      | cfg_valid, cfg_ready, cfg_index,   | in        | valid and ready high
//           | cfg_data                           |           |
//
// Sequence: after an item transfer with no accepted frequency the result is loaded
// directly; otherwise the serial divider is started and takes one quotient bit per
// tick_rate bit, the period is taken, each pulse is a product, then scaled by the
// reciprocal of 100, and the result is loaded. A zero period skips the pulses.
// Reset: asynchronous, active low; state returns to its power-on values and
// the configuration registers to their defaults. The item channel takes a new
// transfer as soon as the previous result is in the output register, even
// while that result is stalled; a stalled result holds until taken.
module keypad_tone_pwm_controller_core
	import ktpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t status;

	// registers take a write in any cycle; writes outside the map are dropped
	assign cfg_ready = 1'b1;

	// sequencer: owns the handshakes, steps the divider and the pulse scaling
	ktpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	// datapath: keypad state update on transfer, then period and pulses
	ktpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item      (item),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

[hw/rtl/ktpc_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module ktpc_divider
	import ktpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W:0]       rem_shift;
	logic [DVS_W+1:0]     diff;
	logic                 fits;

	assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
	assign fits      = ~diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				count_q <= count_q - DIV_CNT_W'(1);
				if (count_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[hw/rtl/ktpc_datapath.sv]
// Keypad state, configuration registers, period and pulse arithmetic.
module ktpc_datapath
	import ktpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 status,
	input  item_t                 item,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output result_t               result
);

	logic [TICK_W-1:0] tick_q;
	logic [FREQ_W-1:0] fmin_q;
	logic [FREQ_W-1:0] fmax_q;
	logic [STEP_W-1:0] step_q;
	logic [DUTY_W-1:0] lim_q;

	digits_t           digits_q, digits_n;
	logic              entry_q, entry_n;
	logic              ilock_q, ilock_n;
	logic              elock_q, elock_n;
	logic [FREQ_W-1:0] freq_q, freq_n;
	logic [DUTY_W-1:0] duty_a_q, duty_a_n;
	logic [DUTY_W-1:0] duty_b_q, duty_b_n;
	logic [1:0]        mode_q, mode_n;
	logic              held_q, held_n;
	logic              err_q, err_n;

	logic [PER_W-1:0]  period_q;
	logic [PER_W-1:0]  pulse_a_q;
	logic [PER_W-1:0]  pulse_b_q;
	result_t           result_q;

	logic [DIGIT_W:0]  dec;
	logic [CMP_W-1:0]  value;
	logic              in_range;
	logic [KEY_W-1:0]  key;

	logic [DVD_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic              div_done;
	logic [DVD_W-1:0]  div_quot;
	logic [DVD_W-1:0]  quot_m1;
	logic [PER_W-1:0]  period_m1;
	logic [DUTY_W-1:0] duty_sel;
	logic [PROD_W-1:0] prod_n;
	logic [PROD_W-1:0] prod_q;
	logic [SCALED_W-1:0]           scaled;
	logic [SCALED_W-PCT_SHIFT-1:0] pct_quot;
	logic [PER_W-1:0]  pulse_sat;
	spk_mode_t         spk;

	function automatic logic [DUTY_W-1:0] step_duty(input logic [DUTY_W-1:0] duty,
			input logic [STEP_W-1:0] step, input logic [DUTY_W-1:0] lim);
		logic [DUTY_W:0] n;
		n = {1'b0, duty} + (DUTY_W + 1)'(step);
		return (n > {1'b0, lim}) ? '0 : n[DUTY_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_RATE_RST;
			fmin_q <= MIN_FREQ_RST;
			fmax_q <= MAX_FREQ_RST;
			step_q <= DUTY_STEP_RST;
			lim_q  <= DUTY_LIM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TICK_RATE: tick_q <= cfg_data[TICK_W-1:0];
				REG_MIN_FREQ:  fmin_q <= cfg_data[FREQ_W-1:0];
				REG_MAX_FREQ:  fmax_q <= cfg_data[FREQ_W-1:0];
				REG_DUTY_STEP: step_q <= cfg_data[STEP_W-1:0];
				REG_DUTY_LIM:  lim_q  <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign key      = item.key_code;
	assign dec      = key_digit(key);
	assign value    = digits_value(digits_q);
	assign in_range = (value >= CMP_W'(fmin_q)) && (value <= CMP_W'(fmax_q));

	always_comb begin
		digits_n = digits_q;
		entry_n  = entry_q;
		ilock_n  = ilock_q;
		elock_n  = elock_q;
		freq_n   = freq_q;
		duty_a_n = duty_a_q;
		duty_b_n = duty_b_q;
		mode_n   = mode_q;
		held_n   = held_q;
		err_n    = 1'b0;
		if (!entry_q) begin
			// an armed press advances the mode; release re-arms
			held_n = item.button_level;
			if (item.button_level && !held_q) begin
				mode_n = mode_q + 2'd1;
			end
			if (key == KEY_NONE) begin
				ilock_n = 1'b0;
			end
			if (key == KEY_ENTER) begin
				entry_n = 1'b1;
			end
			if (!ilock_n) begin
				if (key == KEY_DUTY_A) begin
					duty_a_n = step_duty(duty_a_q, step_q, lim_q);
					ilock_n  = 1'b1;
				end else if (key == KEY_DUTY_B) begin
					duty_b_n = step_duty(duty_b_q, step_q, lim_q);
					ilock_n  = 1'b1;
				end else if (key == KEY_ERR_A || key == KEY_ERR_B) begin
					err_n   = 1'b1;
					ilock_n = 1'b1;
				end
			end
		end else begin
			if (key == KEY_NONE) begin
				elock_n = 1'b0;
			end
			if (!elock_q && key != KEY_NONE) begin
				if (dec[DIGIT_W]) begin
					for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
						digits_n[i] = digits_q[i+1];
					end
					digits_n[DIGIT_COUNT-1] = dec[DIGIT_W-1:0];
					elock_n = 1'b1;
				end else if (key == KEY_DUTY_A || key == KEY_DUTY_B ||
						key == KEY_ERR_A || key == KEY_ERR_B) begin
					err_n = 1'b1;
				end
			end
			if (key == KEY_DONE) begin
				if (in_range) begin
					freq_n   = value[FREQ_W-1:0];
					digits_n = '0;
				end else begin
					err_n = 1'b1;
				end
				entry_n = 1'b0;
			end
		end
		if (err_n) begin
			digits_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			entry_q  <= 1'b0;
			ilock_q  <= 1'b0;
			elock_q  <= 1'b0;
			freq_q   <= '0;
			duty_a_q <= DUTY_RST;
			duty_b_q <= DUTY_RST;
			mode_q   <= SPK_A;
			held_q   <= 1'b0;
			err_q    <= 1'b0;
		end else if (cmd.load_item) begin
			digits_q <= digits_n;
			entry_q  <= entry_n;
			ilock_q  <= ilock_n;
			elock_q  <= elock_n;
			freq_q   <= freq_n;
			duty_a_q <= duty_a_n;
			duty_b_q <= duty_b_n;
			mode_q   <= mode_n;
			held_q   <= held_n;
			err_q    <= err_n;
		end
	end

	// period: tick rate over the frequency in the serial divider
	assign div_dividend = DVD_W'(tick_q);
	assign div_divisor  = freq_q;

	ktpc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign quot_m1 = div_quot - DVD_W'(1);

	// pulse: register duty * (period - 1), then scale it down by the percent
	assign period_m1 = period_q - PER_W'(1);
	assign duty_sel  = (cmd.div_sel == DIV_PULSE_B) ? duty_b_q : duty_a_q;
	assign prod_n    = PROD_W'(duty_sel) * PROD_W'(period_m1);

	always_ff @(posedge clk) begin
		if (cmd.pulse_load) begin
			prod_q <= prod_n;
		end
	end

	assign scaled    = SCALED_W'(prod_q) * SCALED_W'(PCT_RECIP);
	assign pct_quot  = scaled[SCALED_W-1:PCT_SHIFT];
	assign pulse_sat = (|pct_quot[SCALED_W-PCT_SHIFT-1:PER_W]) ? '1 : pct_quot[PER_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			period_q  <= '0;
			pulse_a_q <= '0;
			pulse_b_q <= '0;
		end else if (div_done) begin
			if (div_quot == '0) begin
				period_q <= '0;
			end else if (|quot_m1[DVD_W-1:PER_W]) begin
				period_q <= '1;
			end else begin
				period_q <= quot_m1[PER_W-1:0];
			end
		end else if (cmd.pulse_write) begin
			case (cmd.div_sel)
				DIV_PULSE_A: pulse_a_q <= pulse_sat;
				DIV_PULSE_B: pulse_b_q <= pulse_sat;
				default: ;
			endcase
		end
	end

	assign spk = spk_mode_t'(mode_q);

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q.period_ticks   <= period_q;
			result_q.pulse_a        <= pulse_a_q;
			result_q.pulse_b        <= pulse_b_q;
			result_q.tone_frequency <= freq_q;
			result_q.entering       <= entry_q;
			result_q.error_flash    <= err_q;
			result_q.speaker_a_on   <= (spk == SPK_A) || (spk == SPK_BOTH);
			result_q.speaker_b_on   <= (spk == SPK_B) || (spk == SPK_BOTH);
		end
	end

	assign status.freq_zero   = (freq_q == '0);
	assign status.period_zero = (period_q == '0);
	assign status.div_done    = div_done;
	assign result             = result_q;

endmodule

[hw/rtl/ktpc_ctrl.sv]
// Sequencer for item intake, the period division, the two pulses and the result register.
module ktpc_ctrl
	import ktpc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	output logic  result_valid,
	input  logic  result_stall,
	output cmd_t  cmd,
	input  stat_t status
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PSTART = 8'b0000_0010,
		S_PWAIT  = 8'b0000_0100,
		S_ASTART = 8'b0000_1000,
		S_AWAIT  = 8'b0001_0000,
		S_BSTART = 8'b0010_0000,
		S_BWAIT  = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;
	logic   valid_q;
	logic   out_free;

	assign out_free = !valid_q || !result_stall;

	always_comb begin
		state_n         = state_q;
		cmd.load_item   = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.div_sel     = DIV_PERIOD;
		cmd.pulse_load  = 1'b0;
		cmd.pulse_write = 1'b0;
		cmd.load_result = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_n       = S_PSTART;
				end
			end
			S_PSTART: begin
				if (status.freq_zero) begin
					state_n = S_RESULT;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_PWAIT;
				end
			end
			S_PWAIT: begin
				if (status.div_done) begin
					state_n = S_ASTART;
				end
			end
			S_ASTART: begin
				cmd.div_sel = DIV_PULSE_A;
				if (status.period_zero) begin
					state_n = S_RESULT;
				end else begin
					cmd.pulse_load = 1'b1;
					state_n        = S_AWAIT;
				end
			end
			S_AWAIT: begin
				cmd.div_sel     = DIV_PULSE_A;
				cmd.pulse_write = 1'b1;
				state_n         = S_BSTART;
			end
			S_BSTART: begin
				cmd.div_sel    = DIV_PULSE_B;
				cmd.pulse_load = 1'b1;
				state_n        = S_BWAIT;
			end
			S_BWAIT: begin
				cmd.div_sel     = DIV_PULSE_B;
				cmd.pulse_write = 1'b1;
				state_n         = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_n         = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_result) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = valid_q;

endmodule

[hw/rtl/ktpc_checker.sv]
// Port-level checks for the keypad tone controller core, bound to the top.
module ktpc_checker
	import ktpc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result,
	input logic    cfg_valid,
	input logic    cfg_ready
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// one item at a time: stall straight after a transfer
	a_item_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous one still in work");

	// no frequency means no period and no pulses
	a_no_freq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.tone_frequency == '0 |->
		result.period_ticks == '0 && result.pulse_a == '0 && result.pulse_b == '0)
		else $error("timer values without a frequency");

	// zero period forces zero pulses
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.period_ticks == '0 |->
		result.pulse_a == '0 && result.pulse_b == '0)
		else $error("pulse without a period");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind keypad_tone_pwm_controller_core ktpc_checker u_ktpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

[tb/keypad_tone_pwm_controller_core_tb.sv]
// Testbench of the keypad tone and PWM controller core: directed and random keypad scans.
`timescale 1ns / 100ps

module keypad_tone_pwm_controller_core_tb;
	import ktpc_pkg::*;

	// Timing of the run
	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 6;
	// Quiet time after the last result, so any straggler is covered
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 190;
	localparam int PHASE_COUNT   = 6;

	// Highest code the key field can carry; the block must ignore it
	localparam logic [KEY_W-1:0] KEY_TOP = '1;

	// Tone settings and checks of one controller; notes each item transfer and
	// checks each result transfer against the oldest outstanding expectation.
	class tone_scoreboard;
		logic [TICK_W-1:0] tick_rate;
		logic [FREQ_W-1:0] min_freq;
		logic [FREQ_W-1:0] max_freq;
		logic [STEP_W-1:0] duty_step;
		logic [DUTY_W-1:0] duty_limit;

		digits_t           digits;
		bit                entry_mode;
		bit                idle_lock;
		bit                entry_lock;
		bit                button_held;
		logic [FREQ_W-1:0] tone_freq;
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		spk_mode_t         spk_mode;

		result_t           expected_q[$];
		int                errors;

		function new();
			tick_rate   = TICK_RATE_RST;
			min_freq    = MIN_FREQ_RST;
			max_freq    = MAX_FREQ_RST;
			duty_step   = DUTY_STEP_RST;
			duty_limit  = DUTY_LIM_RST;
			digits      = '0;
			entry_mode  = 1'b0;
			idle_lock   = 1'b0;
			entry_lock  = 1'b0;
			button_held = 1'b0;
			tone_freq   = '0;
			duty_a      = DUTY_RST;
			duty_b      = DUTY_RST;
			spk_mode    = SPK_A;
			errors      = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TICK_RATE: tick_rate  = data[TICK_W-1:0];
				REG_MIN_FREQ:  min_freq   = data[FREQ_W-1:0];
				REG_MAX_FREQ:  max_freq   = data[FREQ_W-1:0];
				REG_DUTY_STEP: duty_step  = data[STEP_W-1:0];
				REG_DUTY_LIM:  duty_limit = data[DUTY_W-1:0];
				default: ;
			endcase
		endfunction

		// Wrap to zero once the duty would pass the limit
		function logic [DUTY_W-1:0] stepped_duty(logic [DUTY_W-1:0] d);
			int unsigned n;
			n = 32'(d) + 32'(duty_step);
			return (n > 32'(duty_limit)) ? '0 : DUTY_W'(n);
		endfunction

		function logic [PER_W-1:0] compare_value(logic [DUTY_W-1:0] d, logic [PER_W-1:0] per);
			int unsigned p;
			if (per == '0)
				return '0;
			p = (32'(d) * (32'(per) - 32'd1)) / 32'(PCT_SCALE);
			return (p > 32'hFFFF) ? '1 : PER_W'(p);
		endfunction

		function void push_digit(digit_t dg);
			for (int i = 0; i < DIGIT_COUNT - 1; i++)
				digits[i] = digits[i + 1];
			digits[DIGIT_COUNT - 1] = dg;
		endfunction

		function void note_item(item_t it);
			logic [KEY_W-1:0] k;
			bit               btn;
			bit               err;
			bit               is_digit;
			digit_t           dg;
			int unsigned      q;
			int unsigned      per;
			int unsigned      v;
			result_t          r;

			k   = it.key_code;
			btn = it.button_level;
			err = 1'b0;
			per = 0;

			if (!entry_mode) begin
				// button first: release arms it, an armed press advances the speakers
				if (!btn)
					button_held = 1'b0;
				if (!button_held && btn) begin
					case (spk_mode)
						SPK_A:    spk_mode = SPK_B;
						SPK_B:    spk_mode = SPK_BOTH;
						SPK_BOTH: spk_mode = SPK_OFF;
						default:  spk_mode = SPK_A;
					endcase
					button_held = 1'b1;
				end
				if (k == KEY_NONE)
					idle_lock = 1'b0;
				if (k == KEY_ENTER)
					entry_mode = 1'b1;
				if (!idle_lock) begin
					if (k == KEY_DUTY_A) begin
						duty_a    = stepped_duty(duty_a);
						idle_lock = 1'b1;
					end else if (k == KEY_DUTY_B) begin
						duty_b    = stepped_duty(duty_b);
						idle_lock = 1'b1;
					end else if (k == KEY_ERR_A || k == KEY_ERR_B) begin
						err       = 1'b1;
						idle_lock = 1'b1;
					end
				end
			end else begin
				if (k == KEY_NONE)
					entry_lock = 1'b0;
				is_digit = 1'b1;
				dg       = '0;
				if (k >= KEY_1 && k <= KEY_3)
					dg = digit_t'(k);
				else if (k >= KEY_4 && k <= KEY_6)
					dg = digit_t'(k - KEY_W'(1));
				else if (k >= KEY_7 && k <= KEY_9)
					dg = digit_t'(k - KEY_W'(2));
				else if (k != KEY_0)
					is_digit = 1'b0;
				if (!entry_lock && k != KEY_NONE) begin
					if (is_digit) begin
						push_digit(dg);
						entry_lock = 1'b1;
					end else if (k == KEY_DUTY_A || k == KEY_DUTY_B ||
							k == KEY_ERR_A || k == KEY_ERR_B) begin
						err = 1'b1;
					end
				end
				// done key ends entry whatever the lock holds
				if (k == KEY_DONE) begin
					v = 0;
					for (int i = 0; i < DIGIT_COUNT; i++)
						v = v * DEC_BASE + 32'(digits[i]);
					if (v >= 32'(min_freq) && v <= 32'(max_freq)) begin
						tone_freq = FREQ_W'(v);
						digits    = '0;
					end else begin
						err = 1'b1;
					end
					entry_mode = 1'b0;
				end
			end
			if (err)
				digits = '0;

			if (tone_freq != '0) begin
				q = 32'(tick_rate) / 32'(tone_freq);
				if (q != 0)
					per = (q - 1 > 32'hFFFF) ? 32'hFFFF : q - 1;
			end

			r.period_ticks   = PER_W'(per);
			r.pulse_a        = compare_value(duty_a, PER_W'(per));
			r.pulse_b        = compare_value(duty_b, PER_W'(per));
			r.tone_frequency = tone_freq;
			r.entering       = entry_mode;
			r.error_flash    = err;
			r.speaker_a_on   = (spk_mode == SPK_A || spk_mode == SPK_BOTH);
			r.speaker_b_on   = (spk_mode == SPK_B || spk_mode == SPK_BOTH);
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with no item outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("period_ticks", want.period_ticks, got.period_ticks);
			compare_field("pulse_a", want.pulse_a, got.pulse_a);
			compare_field("pulse_b", want.pulse_b, got.pulse_b);
			compare_field("tone_frequency", want.tone_frequency, got.tone_frequency);
			compare_field("entering", want.entering, got.entering);
			compare_field("error_flash", want.error_flash, got.error_flash);
			compare_field("speaker_a_on", want.speaker_a_on, got.speaker_a_on);
			compare_field("speaker_b_on", want.speaker_b_on, got.speaker_b_on);
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	tone_scoreboard sb = new();

	// Idle rates in percent of cycles, and the receiver's long hold-off
	int  snd_idle_pct = 8;
	int  rcv_idle_pct = 88;
	int  hold_left    = 0;
	int  items_sent   = 0;
	bit  btn_level    = 1'b0;

	keypad_tone_pwm_controller_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Observe both channels at the edge; results are checked before the item
	// of the same edge is noted, since that result belongs to an older item
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(result);
			if (item_valid && !item_stall)
				sb.note_item(item);
		end
	end

	// Receiver: random stall, or a counted hold-off that fills the block up
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one item and hold it until the transfer; valid is only lowered
	// for a gap, so it never sees two updates in one step
	task automatic send_item(logic [KEY_W-1:0] k, logic b);
		while ($urandom_range(99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid        <= 1'b1;
		item.key_code     <= k;
		item.button_level <= b;
		do
			@(posedge clk);
		while (item_stall);
		items_sent++;
	endtask

	// Send a key with the button now and then toggled underneath it
	task automatic press(logic [KEY_W-1:0] k);
		if ($urandom_range(6) == 0)
			btn_level = ~btn_level;
		send_item(k, btn_level);
	endtask

	// Drop valid, let every result drain, then allow the divider to settle
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Keep valid high across back-to-back writes; the caller drops it
	task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic write_all(int unsigned tick, int unsigned fmin, int unsigned fmax,
			int unsigned step, int unsigned lim);
		put_reg(REG_TICK_RATE, CFG_DATA_W'(tick));
		put_reg(REG_MIN_FREQ, CFG_DATA_W'(fmin));
		put_reg(REG_MAX_FREQ, CFG_DATA_W'(fmax));
		put_reg(REG_DUTY_STEP, CFG_DATA_W'(step));
		put_reg(REG_DUTY_LIM, CFG_DATA_W'(lim));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] digit_key(int unsigned d);
		if (d == 0)
			return KEY_0;
		if (d <= 3)
			return KEY_1 + KEY_W'(d - 1);
		if (d <= 6)
			return KEY_4 + KEY_W'(d - 4);
		return KEY_7 + KEY_W'(d - 7);
	endfunction

	initial begin
		int unsigned      stop_at;
		int unsigned      sel;
		int unsigned      v;
		int unsigned      tick;
		int unsigned      fmin;
		logic [KEY_W-1:0] k;
		int unsigned      dq[$];

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: duty keys and locks, error keys, ignored codes, the
		// button cycling every speaker mode, an empty entry, an entry broken
		// by a duty key, and an accepted frequency at the reset settings
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_DUTY_A, 1'b1);
		send_item(KEY_DUTY_A, 1'b1);
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_DUTY_B, 1'b1);
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_ERR_A, 1'b1);
		send_item(KEY_ERR_B, 1'b0);
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_ERR_B, 1'b0);
		send_item(KEY_TOP, 1'b1);
		send_item(KEY_ENTER, 1'b0);
		send_item(KEY_DONE, 1'b0);
		send_item(KEY_ENTER, 1'b1);
		send_item(digit_key(2), 1'b0);
		send_item(digit_key(2), 1'b0);
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_DUTY_B, 1'b0);
		send_item(digit_key(2), 1'b1);
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_0, 1'b0);
		send_item(KEY_NONE, 1'b0);
		send_item(KEY_0, 1'b0);
		send_item(KEY_TOP, 1'b0);
		send_item(KEY_DONE, 1'b0);
		send_item(KEY_NONE, 1'b0);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_idle();
			case (ph)
				// widest range, finest step, saturated period at 1 Hz
				0: write_all(1000000, 1, 99999, 1, 100);
				// slowest tick, so most frequencies give a zero period
				1: write_all(1000, 1, 99999, 50, 0);
				// low frequencies and duties past 100 to saturate the pulses
				2: write_all(1000000, 1, 30, 7, 127);
				// inverted range: every entered value is refused
				3: write_all($urandom_range(1000000, 1000), 99999, 1,
						$urandom_range(50, 1), $urandom_range(100, 0));
				4: begin
					tick = $urandom_range(1000000, 1000);
					fmin = $urandom_range(500, 1);
					write_all(tick, fmin, $urandom_range(99999, fmin),
						$urandom_range(50, 1), $urandom_range(100, 0));
				end
				default: write_all(TICK_RATE_RST, MIN_FREQ_RST, MAX_FREQ_RST,
						DUTY_STEP_RST, DUTY_LIM_RST);
			endcase

			// slow receiver, then slow sender, then full rate
			if (ph < 2) begin
				snd_idle_pct = 8;
				rcv_idle_pct = 88;
			end else if (ph < 4) begin
				snd_idle_pct = 88;
				rcv_idle_pct = 8;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (ph == 0)
				hold_left = HOLD_CYCLES;

			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at) begin
				sel = $urandom_range(99);
				if (sel < 45) begin
					// frequency entry, mostly well formed
					press(KEY_ENTER);
					if ($urandom_range(4) == 0)
						press(KEY_NONE);
					if (sb.min_freq <= sb.max_freq && $urandom_range(3) != 0)
						v = $urandom_range(sb.max_freq, sb.min_freq);
					else
						v = $urandom_range(99999);
					dq.delete();
					do begin
						dq.push_front(v % DEC_BASE);
						v = v / DEC_BASE;
					end while (v != 0);
					if ($urandom_range(3) == 0)
						while (dq.size() < DIGIT_COUNT)
							dq.push_front(0);
					// an extra leading digit; behind five digits it gets shifted out of the register
					if ($urandom_range(9) == 0)
						dq.push_front($urandom_range(9));
					foreach (dq[i]) begin
						press(digit_key(dq[i]));
						if ($urandom_range(6) == 0)
							press(digit_key(dq[i]));
						if ($urandom_range(19) == 0)
							press(KEY_W'($urandom_range(31)));
						if ($urandom_range(19) != 0)
							press(KEY_NONE);
					end
					press(KEY_DONE);
					press(KEY_NONE);
				end else if (sel < 70) begin
					k = $urandom_range(1) ? KEY_DUTY_A : KEY_DUTY_B;
					repeat ($urandom_range(3, 1)) begin
						press(k);
						if ($urandom_range(3) == 0)
							press(k);
						press(KEY_NONE);
					end
				end else if (sel < 80) begin
					press($urandom_range(1) ? KEY_ERR_A : KEY_ERR_B);
					press(KEY_NONE);
				end else if (sel < 90) begin
					repeat ($urandom_range(4, 1)) begin
						btn_level = ~btn_level;
						send_item(KEY_NONE, btn_level);
					end
				end else begin
					// noise over the whole key field and the button
					repeat ($urandom_range(4, 1))
						send_item(KEY_W'($urandom_range(31)), 1'($urandom_range(1)));
				end
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
